@@ hw/rtl/nldig_pkg.sv @@
// Shared types and constants for the nine-lane distinct index generator.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
`default_nettype none

package nldig_pkg;

  // Default number of generator lanes.
  localparam int LANES_DEF = 9;

  // Number of index fields carried on the result channel.
  localparam int OUT_INDICES = 9;

  // Field widths.
  localparam int LFSR_W = 32;
  localparam int IDX_W  = 16;
  localparam int LANE_W = 4;
  localparam int PROD_W = LFSR_W + IDX_W;

  // Packed widths of the stream data words.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = OUT_INDICES * IDX_W;

  // Galois feedback mask, applied when the bit shifted out is one.
  localparam logic [LFSR_W-1:0] FEEDBACK_MASK = 32'hA300_0000;

  // Population size after reset.
  localparam logic [IDX_W-1:0] POP_SIZE_RST = 16'd150;

  // Request kinds.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_GEN  = 1'b1
  } cmd_t;

  // Control passed from the request register to the lane bank.
  typedef struct packed {
    logic              load_en;
    logic              step_en;
    logic [LANE_W-1:0] lane;
  } bank_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/nldig_lfsr_bank.sv @@
// Generator lanes: one 32-bit Galois LFSR per lane plus the scaling multiply.
// Depends on nldig_pkg; the scaled indices are registered here.
`default_nettype none

module nldig_lfsr_bank #(
  parameter int LANES = nldig_pkg::LANES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire nldig_pkg::bank_ctl_t            ctl,
  input  wire logic [nldig_pkg::LFSR_W-1:0]    seed,
  input  wire logic [nldig_pkg::IDX_W-1:0]     pop_size,
  output logic      [nldig_pkg::IDX_W-1:0]     idx_r [LANES]
);

  logic [nldig_pkg::LFSR_W-1:0] gen_r   [LANES];
  logic [nldig_pkg::LFSR_W-1:0] gen_nxt [LANES];
  logic [nldig_pkg::LFSR_W-1:0] step_v  [LANES];
  logic [nldig_pkg::PROD_W-1:0] prod    [LANES];

  // One Galois step per lane and the fixed-point scale floor(v * pop / 2^32).
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      step_v[k] = {1'b0, gen_r[k][nldig_pkg::LFSR_W-1:1]}
                  ^ (gen_r[k][0] ? nldig_pkg::FEEDBACK_MASK : '0);
      prod[k]   = nldig_pkg::PROD_W'(step_v[k]) * nldig_pkg::PROD_W'(pop_size);
    end
  end

  // Next lane state: a load seeds one lane, a generate request steps them all.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      gen_nxt[k] = gen_r[k];
      if (ctl.step_en) begin
        gen_nxt[k] = step_v[k];
      end else if (ctl.load_en && (ctl.lane == nldig_pkg::LANE_W'(k))) begin
        gen_nxt[k] = seed;
      end
    end
  end

  // Lane registers start at zero until seeded.
  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (!rst_n) begin
        gen_r[k] <= '0;
      end else begin
        gen_r[k] <= gen_nxt[k];
      end
    end
  end

  // Scaled indices are captured with each step.
  always_ff @(posedge clk) begin
    if (ctl.step_en) begin
      for (int k = 0; k < LANES; k++) begin
        idx_r[k] <= prod[k][nldig_pkg::PROD_W-1:nldig_pkg::LFSR_W];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nldig_fixup.sv @@
// Duplicate check over all lane indices and the offset-pattern replacement.
// Depends on nldig_pkg; drives the registered result word and collision flag.
`default_nettype none

module nldig_fixup #(
  parameter int LANES = nldig_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                load_en,
  input  wire logic [nldig_pkg::IDX_W-1:0]         idx [LANES],
  output logic      [nldig_pkg::OUT_DATA_W-1:0]    data_r,
  output logic                                     dup_r
);

  localparam int IW = nldig_pkg::IDX_W;

  logic                                dup;
  logic [nldig_pkg::OUT_DATA_W-1:0]    data_nxt;

  // Any pair of equal indices marks a collision.
  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      for (int j = k + 1; j < LANES; j++) begin
        if (idx[k] == idx[j]) begin
          dup = 1'b1;
        end
      end
    end
  end

  // Field k: index k, or index_0 + k*(k+1)/2 on a collision; zero past LANES.
  for (genvar k = 0; k < nldig_pkg::OUT_INDICES; k++) begin : g_field
    if (k == 0) begin : g_first
      assign data_nxt[IW-1:0] = idx[0];
    end else if (k < LANES) begin : g_lane
      localparam logic [IW-1:0] OFS = IW'((k * (k + 1)) / 2);
      assign data_nxt[k*IW +: IW] = dup ? (idx[0] + OFS) : idx[k];
    end else begin : g_none
      assign data_nxt[k*IW +: IW] = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= data_nxt;
      dup_r  <= dup;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nine_lane_distinct_index_gen_core.sv @@
// Top level of the nine-lane distinct index generator.
// Depends on nldig_pkg, nldig_lfsr_bank and nldig_fixup.
// The block accepts one request per clock cycle while in_tready is high. A load
// request (tuser 0) seeds the lane given in tdata and returns nothing; a lane
// number past the last lane is ignored. A generate request (tuser 1) steps
// every lane and returns one result on the result channel. On the way it
// passes three registers: the request register, the index register (lane step
// plus multiply), and the output register (duplicate check plus fix-up). Each
// stage moves on whenever the stage after it is empty or draining, so a held
// result only stalls the requests queued behind it. Once registered, a load
// request never waits on the result side. pop_size is written through cfg_wr_en
// and must only change while no request is in flight.
`default_nettype none

module nine_lane_distinct_index_gen_core #(
  parameter int LANES = nldig_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration: population size.
  input  wire logic                                cfg_wr_en,
  input  wire logic [nldig_pkg::IDX_W-1:0]         cfg_wr_data,
  // Request channel.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata from bit 0: lane [3:0], seed_value [35:4], zero pad [39:36].
  input  wire logic [nldig_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: cmd.
  input  wire logic                                in_tuser,
  // Result channel.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tdata from bit 0: index_0 .. index_8, 16 bits each.
  output logic      [nldig_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: collision_fixed.
  output logic                                     out_tuser
);

  localparam int LW = nldig_pkg::LANE_W;

  logic [nldig_pkg::IDX_W-1:0]         pop_r;
  logic                                s1_valid_r, s1_valid_nxt;
  nldig_pkg::cmd_t                     cmd_r;
  logic [LW-1:0]                       lane_r;
  logic [nldig_pkg::LFSR_W-1:0]        seed_r;
  logic                                s2_valid_r, s2_valid_nxt;
  logic                                s3_valid_r, s3_valid_nxt;
  logic                                s3_free, s2_free, s2_adv, s1_adv, s1_free;
  logic                                in_take;
  nldig_pkg::bank_ctl_t                bank_ctl;
  logic [nldig_pkg::IDX_W-1:0]         idx [LANES];

  // Population size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= nldig_pkg::POP_SIZE_RST;
    end else if (cfg_wr_en) begin
      pop_r <= cfg_wr_data;
    end
  end

  // Stage flow: a stage advances when the next is free; a load always advances.
  always_comb begin
    s3_free   = !s3_valid_r || out_tready;
    s2_adv    = s2_valid_r && s3_free;
    s2_free   = !s2_valid_r || s3_free;
    s1_adv    = s1_valid_r && ((cmd_r == nldig_pkg::CMD_LOAD) || s2_free);
    s1_free   = !s1_valid_r || s1_adv;
    in_tready = s1_free;
    in_take   = in_tvalid && s1_free;

    bank_ctl.load_en = s1_valid_r && (cmd_r == nldig_pkg::CMD_LOAD)
                       && (32'(lane_r) < LANES);
    bank_ctl.step_en = s1_valid_r && (cmd_r == nldig_pkg::CMD_GEN) && s2_free;
    bank_ctl.lane    = lane_r;

    s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s2_valid_nxt = bank_ctl.step_en ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    s3_valid_nxt = s2_adv ? 1'b1 : (out_tready ? 1'b0 : s3_valid_r);
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= nldig_pkg::cmd_t'(in_tuser);
      lane_r <= in_tdata[LW-1:0];
      seed_r <= in_tdata[LW +: nldig_pkg::LFSR_W];
    end
  end

  nldig_lfsr_bank #(
    .LANES (LANES)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (bank_ctl),
    .seed     (seed_r),
    .pop_size (pop_r),
    .idx_r    (idx)
  );

  nldig_fixup #(
    .LANES (LANES)
  ) u_fixup (
    .clk     (clk),
    .load_en (s2_adv),
    .idx     (idx),
    .data_r  (out_tdata),
    .dup_r   (out_tuser)
  );

  assign out_tvalid = s3_valid_r;

endmodule

`default_nettype wire

@@ tb/nine_lane_distinct_index_gen_core_tb.sv @@
// Self-checking testbench for nine_lane_distinct_index_gen_core.
// It uses nldig_pkg for widths, the feedback mask and the request kinds.
// It runs a directed table, then random requests under three idle patterns.
`default_nettype none

module nine_lane_distinct_index_gen_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nldig_pkg::*;

  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int HALF_PHASE    = 300;

  // One index set as it travels on the result channel: index_0 in the lowest bits.
  typedef struct packed {
    logic [OUT_INDICES-1:0][IDX_W-1:0] idx;
    logic                              coll;
  } idx_set_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [LANE_W-1:0] lane;
    logic [LFSR_W-1:0] seed;
    logic [IDX_W-1:0]  cfg_val;
    bit                typed;
    idx_set_t          want;
  } dir_row_t;

  // All lanes equal: index_0 plus the triangular offsets, collision raised.
  localparam idx_set_t ZERO_COLLIDE = {16'd36, 16'd28, 16'd21, 16'd15, 16'd10,
                                       16'd6, 16'd3, 16'd1, 16'd0, 1'b1};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [IDX_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Shadow copy of the generator state and the population size.
  logic [LFSR_W-1:0] lane_lfsr [LANES_DEF];
  logic [IDX_W-1:0]  pop_limit;

  idx_set_t pending_sets[$];
  dir_row_t dir_rows[$];
  int       mismatches;
  int       results_seen;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_off;

  nine_lane_distinct_index_gen_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Steps every lane once and scales it; duplicates force the offset pattern.
  function automatic idx_set_t step_lanes();
    idx_set_t          r;
    logic [PROD_W-1:0] prod;
    logic [LFSR_W-1:0] v;
    bit                dup;
    r = '0;
    dup = 1'b0;
    for (int k = 0; k < LANES_DEF; k++) begin
      v = lane_lfsr[k] >> 1;
      if (lane_lfsr[k][0]) begin
        v = v ^ FEEDBACK_MASK;
      end
      lane_lfsr[k] = v;
      prod = PROD_W'(v) * PROD_W'(pop_limit);
      r.idx[k] = prod[PROD_W-1:LFSR_W];
    end
    for (int k = 0; k < LANES_DEF; k++) begin
      for (int j = k + 1; j < LANES_DEF; j++) begin
        if (r.idx[k] == r.idx[j]) begin
          dup = 1'b1;
        end
      end
    end
    if (dup) begin
      for (int k = 1; k < OUT_INDICES; k++) begin
        r.idx[k] = IDX_W'(r.idx[0] + k * (k + 1) / 2);
      end
    end
    r.coll = dup;
    return r;
  endfunction

  // Offers one request, waits for the handshake, then updates the shadow state.
  task automatic send_request(cmd_t c, logic [LANE_W-1:0] lane, logic [LFSR_W-1:0] seed,
                              bit typed, idx_set_t want);
    idx_set_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {4'b0, seed, lane};
    do @(posedge clk); while (!in_tready);
    if (c == CMD_GEN) begin
      pred = step_lanes();
      pending_sets.push_back(typed ? want : pred);
    end else if (lane < LANES_DEF) begin
      lane_lfsr[lane] = seed;
    end
  endtask

  // Drains the pipeline, then writes the population size.
  task automatic write_pop_size(logic [IDX_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    // A load request leaves no result, so allow for one still in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    pop_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic dir_row_t req_row(cmd_t c, logic [LANE_W-1:0] lane,
                                       logic [LFSR_W-1:0] seed);
    dir_row_t r;
    r = '{kind: ROW_REQ, cmd: c, lane: lane, seed: seed, cfg_val: '0, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [IDX_W-1:0] value);
    dir_row_t r;
    r = req_row(CMD_LOAD, '0, '0);
    r.kind = ROW_CFG;
    r.cfg_val = value;
    return r;
  endfunction

  function automatic dir_row_t typed_gen_row(idx_set_t want);
    dir_row_t r;
    r = req_row(CMD_GEN, '0, '0);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  // Random seed with a bias toward zero, all ones and single bits.
  function automatic logic [LFSR_W-1:0] pick_seed();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return '1;
    end else if (sel == 2) begin
      return LFSR_W'(1) << $urandom_range(LFSR_W - 1);
    end
    return $urandom;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expected index set.
  always @(posedge clk) begin
    idx_set_t got;
    idx_set_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (pending_sets.size() == 0) begin
        report_mismatch("result arrived with none expected");
      end else begin
        want = pending_sets.pop_front();
        for (int k = 0; k < OUT_INDICES; k++) begin
          if (got.idx[k] !== want.idx[k]) begin
            report_mismatch($sformatf("index_%0d got %0d, expected %0d",
                                      k, got.idx[k], want.idx[k]));
          end
        end
        if (got.coll !== want.coll) begin
          report_mismatch($sformatf("collision_fixed got %b, expected %b",
                                    got.coll, want.coll));
        end
      end
      results_seen++;
    end
  end

  initial begin
    cmd_t              c;
    logic [LANE_W-1:0] lane;
    logic [IDX_W-1:0]  pops [3][2];
    int                send_pct [3];
    int                recv_pct [3];

    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    hold_off     = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    foreach (lane_lfsr[k]) lane_lfsr[k] = '0;
    pop_limit = POP_SIZE_RST;

    send_pct = '{19, 87, 0};
    recv_pct = '{87, 19, 0};
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset state, ignored lanes, seed extremes, pop_size extremes.
    dir_rows.push_back(typed_gen_row(ZERO_COLLIDE));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd9, 32'h1234_5678));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd15, 32'hFFFF_FFFF));
    dir_rows.push_back(typed_gen_row(ZERO_COLLIDE));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd0, 32'hFFFF_FFFF));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd1, 32'h0000_0001));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd2, 32'h8000_0000));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd3, 32'h5555_5555));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd4, 32'hAAAA_AAAA));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd5, 32'h0000_0002));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd6, 32'hDEAD_BEEF));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd7, 32'h0F0F_0F0F));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd8, 32'hF0F0_F0F0));
    dir_rows.push_back(req_row(CMD_GEN, 4'd0, 32'h0));
    dir_rows.push_back(req_row(CMD_GEN, 4'd0, 32'h0));
    dir_rows.push_back(cfg_row(16'hFFFF));
    dir_rows.push_back(req_row(CMD_GEN, 4'd0, 32'h0));
    // Lane zero steps to all ones, so the offset pattern wraps past 2^16.
    dir_rows.push_back(req_row(CMD_LOAD, 4'd0, 32'hB9FF_FFFF));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd1, 32'h0));
    dir_rows.push_back(req_row(CMD_LOAD, 4'd2, 32'h0));
    dir_rows.push_back(req_row(CMD_GEN, 4'd0, 32'h0));
    dir_rows.push_back(cfg_row(16'd1));
    dir_rows.push_back(typed_gen_row(ZERO_COLLIDE));
    dir_rows.push_back(cfg_row(16'd0));
    dir_rows.push_back(typed_gen_row(ZERO_COLLIDE));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_pop_size(dir_rows[i].cfg_val);
      end else begin
        send_request(dir_rows[i].cmd, dir_rows[i].lane, dir_rows[i].seed,
                     dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part: three idle patterns, two population sizes in each.
    pops[0][0] = 16'd9;
    pops[0][1] = 16'($urandom_range(10, 200));
    pops[1][0] = 16'($urandom);
    pops[1][1] = 16'hFFFF;
    pops[2][0] = 16'($urandom_range(1, 8));
    pops[2][1] = POP_SIZE_RST;

    for (int p = 0; p < 3; p++) begin
      for (int h = 0; h < 2; h++) begin
        write_pop_size(pops[p][h]);
        send_idle_pct = send_pct[p];
        recv_idle_pct = recv_pct[p];
        // With no idling, stall the result side long enough to back up the input.
        if (p == 2 && h == 0) begin
          hold_off = 1'b1;
        end
        for (int n = 0; n < HALF_PHASE; n++) begin
          c = ($urandom_range(99) < 45) ? CMD_GEN : CMD_LOAD;
          if ($urandom_range(9) == 0) begin
            lane = LANE_W'($urandom_range(LANES_DEF, 15));
          end else begin
            lane = LANE_W'($urandom_range(LANES_DEF - 1));
          end
          send_request(c, lane, pick_seed(), 1'b0, '0);
        end
      end
    end

    // Wait for every expected result, then watch for strays.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
